// File: hw/rtl/pcmcl_pkg.sv
// ============================================================================
// pcmcl_pkg - shared types and constants for the PCM chunk loader and mixer
// Opcodes, load phases, status codes, controller states and the
// command/status structs between the controller and the datapath.
// ============================================================================
package pcmcl_pkg;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_MIX  = 2'd1,
        OP_STOP = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_SAMPLES = 2'd2,
        PH_DISCARD = 2'd3
    } t_load_phase;

    typedef enum logic [1:0] {
        STAT_NONE = 2'd0,
        STAT_BUSY = 2'd1,
        STAT_DONE = 2'd2,
        STAT_ERR  = 2'd3
    } t_status;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } t_ctrl_state;

    // controller -> datapath
    typedef struct packed {
        logic take;   // latch request fields, read sample store
        logic exec;   // update state, load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_full;
    } t_dp_stat;

    localparam logic [15:0] DEFAULT_RATE_RESET = 16'd44100;
    localparam logic [15:0] SAMPLE_POS_MAX     = 16'h7FFF;
    localparam logic [15:0] SAMPLE_NEG_MAX     = 16'h8000;
    localparam logic [15:0] MIXED_COUNT_MAX    = 16'hFFFF;
    localparam int          HEADER_BYTES       = 6;
    localparam int          COUNT_BYTES        = 4;

endpackage

// File: hw/rtl/pcm_chunk_loader_and_mixer.sv
// ============================================================================
// pcm_chunk_loader_and_mixer - PCM chunk loader with saturating one-shot mixer
// Loads a sample chunk byte by byte and mixes it into an audio stream.
// ============================================================================
// Usage:
//   Requests enter on s_axis: tuser carries the opcode (load byte, mix, stop),
//   tdata the load byte and the sample to mix into, tlast ends a chunk or a
//   mix buffer. Every request gives exactly one result on m_axis.
//   A chunk is a 32-bit sample count, a 16-bit rate and int16 samples, all
//   little endian; its last byte reports load done (with the rate) or error.
//   A good load starts playback; each mix request adds the next stored sample
//   halved to the input sample, saturating to 16 bits.
//   i_cfg_wr_en / i_cfg_wr_data set the rate reported for a header rate of 0.
// Timing:
//   Each request is taken in IDLE, where the sample store is read (registered
//   read port), then committed in EXEC, which updates the state and loads the
//   output register. s_axis takes no new request while one is in EXEC, and
//   it is ready again in the same cycle that the result becomes valid on m_axis.
//   When m_axis stalls, one result waits in the output register; the request
//   behind it is held until that result is taken.
// Reset: synchronous, active low. Clears the loader, playback and output
//   valid; the sample store needs no clearing since playback only reads
//   entries written by the current chunk.
module pcm_chunk_loader_and_mixer #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] load_byte, [23:8] in_sample
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] out_sample, [31:16] mixed_count,
                                        // [47:32] chunk_rate
    output logic [2:0]  m_axis_tuser    // [0] sample_added, [2:1] status
);

    pcmcl_pkg::t_dp_cmd  w_cmd;
    pcmcl_pkg::t_dp_stat w_stat;
    logic [15:0]         w_out_sample;
    logic                w_sample_added;
    logic [15:0]         w_mixed_count;
    logic [1:0]          w_status;
    logic [15:0]         w_chunk_rate;

    pcmcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pcmcl_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_opcode       (s_axis_tuser),
        .i_load_byte    (s_axis_tdata[7:0]),
        .i_in_sample    (s_axis_tdata[23:8]),
        .i_last         (s_axis_tlast),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_sample   (w_out_sample),
        .o_sample_added (w_sample_added),
        .o_mixed_count  (w_mixed_count),
        .o_status       (w_status),
        .o_chunk_rate   (w_chunk_rate)
    );

    assign m_axis_tdata = {w_chunk_rate, w_mixed_count, w_out_sample};
    assign m_axis_tuser = {w_status, w_sample_added};

endmodule

// File: hw/rtl/pcmcl_ctrl.sv
// ============================================================================
// pcmcl_ctrl - request sequencer
// Takes one request, lets the datapath read the sample store, then commits
// the request once the output register is free.
// ============================================================================
module pcmcl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic               i_out_ready,
    input  pcmcl_pkg::t_dp_stat i_stat,
    output pcmcl_pkg::t_dp_cmd  o_cmd
);

    pcmcl_pkg::t_ctrl_state r_state;
    pcmcl_pkg::t_ctrl_state n_state;
    logic                   w_out_free;

    assign w_out_free = !i_stat.out_full || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcmcl_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcmcl_pkg::CS_IDLE: begin
                if (i_req_valid) begin
                    n_state = pcmcl_pkg::CS_EXEC;
                end
            end
            pcmcl_pkg::CS_EXEC: begin
                if (w_out_free) begin
                    n_state = pcmcl_pkg::CS_IDLE;
                end
            end
            default: n_state = pcmcl_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            pcmcl_pkg::CS_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.take  = i_req_valid;
            end
            pcmcl_pkg::CS_EXEC: begin
                o_cmd.exec = w_out_free;
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_take_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> (r_state == pcmcl_pkg::CS_EXEC))
        else $error("accepted request did not move to execute");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_stat.out_full && !i_out_ready) |-> !o_cmd.exec)
        else $error("result committed over an untaken result");
`endif

endmodule

// File: hw/rtl/pcmcl_datapath.sv
// ============================================================================
// pcmcl_datapath - chunk parser, sample store and saturating mixer
// Holds the load/playback state, the sample memory and the output register.
// ============================================================================
module pcmcl_datapath #(
    parameter  int MAX_SAMPLES = 4096,
    localparam int CW          = $clog2(MAX_SAMPLES + 1),
    localparam int AW          = $clog2(MAX_SAMPLES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcmcl_pkg::t_dp_cmd  i_cmd,
    output pcmcl_pkg::t_dp_stat o_stat,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  logic [1:0]          i_opcode,
    input  logic [7:0]          i_load_byte,
    input  logic [15:0]         i_in_sample,
    input  logic                i_last,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [15:0]         o_out_sample,
    output logic                o_sample_added,
    output logic [15:0]         o_mixed_count,
    output logic [1:0]          o_status,
    output logic [15:0]         o_chunk_rate
);

    logic [15:0] r_mem [MAX_SAMPLES];
    logic [15:0] r_rd_data;

    // latched request
    pcmcl_pkg::t_opcode r_op;
    logic [7:0]         r_byte;
    logic [15:0]        r_x;
    logic               r_last;

    // persistent state
    logic [15:0]            r_default_rate;
    logic [CW-1:0]          r_total,    n_total;
    logic [CW-1:0]          r_pos,      n_pos;
    logic                   r_playing,  n_playing;
    logic [31:0]            r_hdr,      n_hdr;
    pcmcl_pkg::t_load_phase r_phase,    n_phase;
    logic [2:0]             r_idx,      n_idx;
    logic [7:0]             r_low,      n_low;
    logic [CW-1:0]          r_decl,     n_decl;
    logic [15:0]            r_buf,      n_buf;

    // result of the current request
    logic [15:0]       w_y;
    logic              w_added;
    logic [15:0]       w_count;
    pcmcl_pkg::t_status w_status;
    logic [15:0]       w_rate;

    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [15:0]       w_wr_data;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_sample;
    logic        r_out_added;
    logic [15:0] r_out_count;
    logic [1:0]  r_out_status;
    logic [15:0] r_out_rate;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op      <= pcmcl_pkg::t_opcode'(i_opcode);
            r_byte    <= i_load_byte;
            r_x       <= i_in_sample;
            r_last    <= i_last;
            r_rd_data <= r_mem[r_pos[AW-1:0]];
        end
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_comb begin
        logic [31:0]        hdr_new;
        logic signed [15:0] half;
        logic signed [16:0] sum;
        logic               finished;

        n_total   = r_total;
        n_pos     = r_pos;
        n_playing = r_playing;
        n_hdr     = r_hdr;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_low     = r_low;
        n_decl    = r_decl;
        n_buf     = r_buf;
        w_y       = '0;
        w_added   = 1'b0;
        w_count   = '0;
        w_status  = pcmcl_pkg::STAT_NONE;
        w_rate    = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_total[AW-1:0];
        w_wr_data = {r_byte, r_low};
        hdr_new   = '0;
        half      = '0;
        sum       = '0;
        finished  = 1'b0;

        case (r_op)
            pcmcl_pkg::OP_LOAD: begin
                if (r_phase == pcmcl_pkg::PH_IDLE) begin
                    // new chunk: drop whatever was stored
                    n_total   = '0;
                    n_pos     = '0;
                    n_playing = 1'b0;
                    n_hdr     = '0;
                    n_idx     = '0;
                    n_low     = '0;
                    n_decl    = '0;
                    n_phase   = pcmcl_pkg::PH_HEADER;
                end
                case (n_phase)
                    pcmcl_pkg::PH_HEADER: begin
                        // count bytes 0..3 then rate bytes 4..5, little endian
                        hdr_new = n_hdr | (32'(r_byte) << {n_idx[1:0], 3'b000});
                        n_hdr   = hdr_new;
                        if (n_idx == 3'(pcmcl_pkg::COUNT_BYTES - 1)) begin
                            if (hdr_new == '0 || hdr_new > 32'(MAX_SAMPLES)) begin
                                n_phase = pcmcl_pkg::PH_DISCARD;
                            end else begin
                                n_decl = hdr_new[CW-1:0];
                                n_hdr  = '0;
                            end
                        end
                        n_idx = n_idx + 3'd1;
                        if (n_phase == pcmcl_pkg::PH_HEADER &&
                            n_idx == 3'(pcmcl_pkg::HEADER_BYTES)) begin
                            n_phase = pcmcl_pkg::PH_SAMPLES;
                            n_idx   = '0;
                        end else if (r_last) begin
                            n_phase   = pcmcl_pkg::PH_IDLE;
                            n_total   = '0;
                            n_pos     = '0;
                            n_playing = 1'b0;
                            w_status  = pcmcl_pkg::STAT_ERR;
                            finished  = 1'b1;
                        end
                    end
                    pcmcl_pkg::PH_SAMPLES: begin
                        if (!n_idx[0]) begin
                            n_low = r_byte;
                        end else if (n_total < n_decl) begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = n_total[AW-1:0];
                            w_wr_data = {r_byte, n_low};
                            n_total   = n_total + CW'(1);
                        end
                        n_idx[0] = ~n_idx[0];
                    end
                    default: ;
                endcase
                if (!finished) begin
                    if (!r_last) begin
                        w_status = pcmcl_pkg::STAT_BUSY;
                    end else if (n_phase != pcmcl_pkg::PH_SAMPLES || n_total == '0) begin
                        n_phase   = pcmcl_pkg::PH_IDLE;
                        n_total   = '0;
                        n_pos     = '0;
                        n_playing = 1'b0;
                        w_status  = pcmcl_pkg::STAT_ERR;
                    end else begin
                        n_phase   = pcmcl_pkg::PH_IDLE;
                        n_pos     = '0;
                        n_playing = 1'b1;
                        w_rate    = (n_hdr[15:0] != '0) ? n_hdr[15:0] : r_default_rate;
                        w_status  = pcmcl_pkg::STAT_DONE;
                    end
                end
            end
            pcmcl_pkg::OP_MIX: begin
                w_y = r_x;
                if (r_playing && r_pos >= r_total) begin
                    n_playing = 1'b0;
                end
                if (n_playing) begin
                    half = $signed(r_rd_data) >>> 1;
                    sum  = $signed({r_x[15], r_x}) + $signed({half[15], half});
                    if (sum[16] != sum[15]) begin
                        w_y = sum[16] ? pcmcl_pkg::SAMPLE_NEG_MAX
                                      : pcmcl_pkg::SAMPLE_POS_MAX;
                    end else begin
                        w_y = sum[15:0];
                    end
                    n_pos   = r_pos + CW'(1);
                    w_added = 1'b1;
                    if (r_buf != pcmcl_pkg::MIXED_COUNT_MAX) begin
                        n_buf = r_buf + 16'd1;
                    end
                end
                w_count = n_buf;
                if (r_last) begin
                    n_buf = '0;
                end
            end
            pcmcl_pkg::OP_STOP: begin
                n_phase   = pcmcl_pkg::PH_IDLE;
                n_total   = '0;
                n_pos     = '0;
                n_playing = 1'b0;
            end
            default: ;
        endcase

        if (!i_cmd.exec) begin
            w_wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_rate <= pcmcl_pkg::DEFAULT_RATE_RESET;
            r_total        <= '0;
            r_pos          <= '0;
            r_playing      <= 1'b0;
            r_hdr          <= '0;
            r_phase        <= pcmcl_pkg::PH_IDLE;
            r_idx          <= '0;
            r_low          <= '0;
            r_decl         <= '0;
            r_buf          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_default_rate <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_total     <= n_total;
                r_pos       <= n_pos;
                r_playing   <= n_playing;
                r_hdr       <= n_hdr;
                r_phase     <= n_phase;
                r_idx       <= n_idx;
                r_low       <= n_low;
                r_decl      <= n_decl;
                r_buf       <= n_buf;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_sample <= w_y;
            r_out_added  <= w_added;
            r_out_count  <= w_count;
            r_out_status <= w_status;
            r_out_rate   <= w_rate;
        end
    end

    assign o_stat.out_full = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_out_sample    = r_out_sample;
    assign o_sample_added  = r_out_added;
    assign o_mixed_count   = r_out_count;
    assign o_status        = r_out_status;
    assign o_chunk_rate    = r_out_rate;

`ifndef SYNTH
    a_total_within_decl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_decl)
        else $error("stored sample count above declared count");
    a_pos_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_pos <= r_total))
        else $error("play position past stored samples");
    a_added_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_added) |-> (r_out_count != '0))
        else $error("mixed sample reported with zero count");
`endif

endmodule
